[hdl/message_queue_with_wait_lists_unit_defines.svh]
// ----------------------------------------------------------------------------
// message queue with wait lists - assertion macros
// Shared assertion forms for the message queue unit.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_QUEUE_WITH_WAIT_LISTS_UNIT_DEFINES_SVH
`define MESSAGE_QUEUE_WITH_WAIT_LISTS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MQWL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MQWL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mqwl_pkg.sv]
// ----------------------------------------------------------------------------
// mqwl_pkg
// Types, sizes and codes shared by the message queue with wait lists.
// ----------------------------------------------------------------------------
package mqwl_pkg;

   // sizes
   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int MAX_TASKS   = 8;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int FILL_W      = 5;
   localparam int TASK_W      = 3;
   localparam int LCNT_W      = $clog2(MAX_TASKS + 1);
   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   // request codes
   localparam logic [ACTION_W-1:0] ACT_SEND_BLOCK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RECV_BLOCK    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SEND_NONBLOCK = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RECV_NONBLOCK = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK          = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_RESET         = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTIFY_ENABLE = 1'd1;

   // control state
   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   // wait list command and status
   typedef struct packed {
      logic              pop;
      logic              append;
      logic [TASK_W-1:0] task_id;
   } wl_cmd_type;

   typedef struct packed {
      logic              empty;
      logic              single;
      logic [TASK_W-1:0] head;
   } wl_stat_type;

endpackage

[hdl/mqwl_ram.sv]
// ----------------------------------------------------------------------------
// mqwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqwl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/mqwl_wait_list.sv]
// ----------------------------------------------------------------------------
// mqwl_wait_list
// Ordered list of waiting task numbers: pop from the head, or append at the
// tail after dropping an earlier entry of the same task.
// ----------------------------------------------------------------------------
module mqwl_wait_list (
   input  logic                clock,
   input  logic                reset,
   input  mqwl_pkg::wl_cmd_type  cmd,
   output mqwl_pkg::wl_stat_type stat
);

   logic [mqwl_pkg::TASK_W-1:0] entries_ff [mqwl_pkg::MAX_TASKS];
   logic [mqwl_pkg::TASK_W-1:0] entries_in [mqwl_pkg::MAX_TASKS];
   logic [mqwl_pkg::LCNT_W-1:0] count_ff;
   logic [mqwl_pkg::LCNT_W-1:0] count_in;
   logic [mqwl_pkg::MAX_TASKS-1:0] hit_vec;
   logic [mqwl_pkg::TASK_W-1:0]    hit_pos;
   logic [mqwl_pkg::TASK_W-1:0]    rm_pos;
   logic                           rm_hit;
   logic [mqwl_pkg::LCNT_W-1:0]    cnt_mid;

   // parallel match against the live entries, first hit wins
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < mqwl_pkg::MAX_TASKS; i++) begin
         hit_vec[i] = (mqwl_pkg::LCNT_W'(i) < count_ff) && (entries_ff[i] == cmd.task_id);
      end
      for (int i = mqwl_pkg::MAX_TASKS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_pos = mqwl_pkg::TASK_W'(i);
         end
      end
   end

   // remove one entry and close the gap, then append at the tail
   always_comb begin
      rm_hit = 1'b0;
      rm_pos = '0;
      if (cmd.pop) begin
         rm_hit = (count_ff != '0);
      end else if (cmd.append) begin
         rm_hit = |hit_vec;
         rm_pos = hit_pos;
      end
      for (int i = 0; i < mqwl_pkg::MAX_TASKS; i++) begin
         entries_in[i] = entries_ff[i];
      end
      for (int i = 0; i < mqwl_pkg::MAX_TASKS - 1; i++) begin
         if (rm_hit && (mqwl_pkg::TASK_W'(i) >= rm_pos)) begin
            entries_in[i] = entries_ff[i + 1];
         end
      end
      cnt_mid  = count_ff - mqwl_pkg::LCNT_W'(rm_hit);
      count_in = cnt_mid;
      if (cmd.append && (cnt_mid < mqwl_pkg::LCNT_W'(mqwl_pkg::MAX_TASKS))) begin
         entries_in[cnt_mid[mqwl_pkg::TASK_W-1:0]] = cmd.task_id;
         count_in = cnt_mid + mqwl_pkg::LCNT_W'(1);
      end
   end

   // list entries
   always_ff @(posedge clock) begin
      for (int i = 0; i < mqwl_pkg::MAX_TASKS; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.empty  = (count_ff == '0);
   assign stat.single = (count_ff == mqwl_pkg::LCNT_W'(1));
   assign stat.head   = entries_ff[0];

endmodule

[hdl/message_queue_with_wait_lists_unit.sv]
// ----------------------------------------------------------------------------
// message_queue_with_wait_lists_unit
// Task message queue: circular word store in RAM, receiver and sender wait
// lists, with blocking, non-blocking, peek and reset requests.
// ----------------------------------------------------------------------------
//
//  channel   ports                       handshake
//  --------  --------------------------  -------------------------------
//  request   start, busy, req_*          taken when start & !busy
//  result    rsp_strobe, rsp_*           one-cycle strobe per result, no stall
//  control   csr_write_enable, csr_*     written when write enable high
//
//  Each request gives its result in the cycle after it is taken; a word read
//  comes straight from the registered RAM output in that cycle.
//  A new request may be taken every cycle, except during a reset request
//  with N senders waiting, which holds busy for N-1 cycles while the sender
//  list drains one task a cycle; undefined request codes give no result.
//  Synchronous reset empties the queue and both wait lists at once.
//  The receiver cannot stall results.
//
module message_queue_with_wait_lists_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mqwl_pkg::ACTION_W-1:0]         req_action,
   input  logic [mqwl_pkg::TASK_W-1:0]           req_task_id,
   input  logic [31:0]                           req_send_data,
   output logic                                  rsp_strobe,
   output logic [mqwl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [31:0]                           rsp_read_data,
   output logic                                  rsp_woken_valid,
   output logic [mqwl_pkg::TASK_W-1:0]           rsp_woken_task,
   output logic                                  rsp_notify,
   output logic [mqwl_pkg::FILL_W-1:0]           rsp_fill_level,
   output logic                                  rsp_last,
   input  logic                                  csr_write_enable,
   input  logic [mqwl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mqwl_pkg::CSR_DATA_W-1:0]       csr_write_data
);

`include "message_queue_with_wait_lists_unit_defines.svh"

   // control and queue state
   mqwl_pkg::state_type          state_ff, state_in;
   logic [mqwl_pkg::FILL_W-1:0]  held_ff, held_in;
   logic [mqwl_pkg::IDX_W-1:0]   ri_ff, ri_in;
   logic [mqwl_pkg::IDX_W-1:0]   wi_ff, wi_in;
   logic [mqwl_pkg::FILL_W-1:0]  cap_ff;
   logic                         notify_en_ff;

   // result registers
   logic                         strobe_ff, strobe_in;
   logic [mqwl_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         rd_sel_ff, rd_sel_in;
   logic                         woken_valid_ff, woken_valid_in;
   logic [mqwl_pkg::TASK_W-1:0]  woken_task_ff, woken_task_in;
   logic                         notify_ff, notify_in;
   logic [mqwl_pkg::FILL_W-1:0]  fill_ff;
   logic                         last_ff, last_in;

   // fsm outputs and datapath signals
   logic                         accept;
   logic                         drain_pop;
   logic [mqwl_pkg::FILL_W-1:0]  eff_cap;
   logic                         has_room;
   logic                         has_word;
   logic                         ram_we;
   logic                         ram_re;
   logic [mqwl_pkg::DATA_WIDTH-1:0] ram_rd_data;
   mqwl_pkg::wl_cmd_type         rx_cmd, tx_cmd;
   mqwl_pkg::wl_stat_type        rx_stat, tx_stat;

   // next index with wrap at the effective capacity
   function automatic logic [mqwl_pkg::IDX_W-1:0] advance(
      input logic [mqwl_pkg::IDX_W-1:0]  idx,
      input logic [mqwl_pkg::FILL_W-1:0] cap
   );
      logic [mqwl_pkg::FILL_W-1:0] n;
      n = mqwl_pkg::FILL_W'(idx) + mqwl_pkg::FILL_W'(1);
      return (n >= cap) ? '0 : n[mqwl_pkg::IDX_W-1:0];
   endfunction

   assign accept = start && !busy;

   // effective capacity: zero acts as one, above depth acts as depth
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = mqwl_pkg::FILL_W'(1);
      end else if (cap_ff > mqwl_pkg::FILL_W'(mqwl_pkg::DEPTH)) begin
         eff_cap = mqwl_pkg::FILL_W'(mqwl_pkg::DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign has_room = (held_ff < eff_cap);
   assign has_word = (held_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqwl_pkg::ST_IDLE: begin
            if (accept && (req_action == mqwl_pkg::ACT_RESET) &&
                !tx_stat.empty && !tx_stat.single) begin
               state_in = mqwl_pkg::ST_DRAIN;
            end
         end
         mqwl_pkg::ST_DRAIN: begin
            if (tx_stat.single) begin
               state_in = mqwl_pkg::ST_IDLE;
            end
         end
         default: state_in = mqwl_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      busy      = 1'b0;
      drain_pop = 1'b0;
      unique case (state_ff)
         mqwl_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         mqwl_pkg::ST_DRAIN: begin
            busy      = 1'b1;
            drain_pop = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   // request decode: store access, index update, wait lists, result fields
   always_comb begin
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      held_in        = held_ff;
      ri_in          = ri_ff;
      wi_in          = wi_ff;
      rx_cmd         = '{pop: 1'b0, append: 1'b0, task_id: req_task_id};
      tx_cmd         = '{pop: 1'b0, append: 1'b0, task_id: req_task_id};
      strobe_in      = 1'b0;
      status_in      = mqwl_pkg::STATUS_DONE;
      rd_sel_in      = 1'b0;
      woken_valid_in = 1'b0;
      woken_task_in  = '0;
      notify_in      = 1'b0;
      last_in        = 1'b1;
      if (drain_pop) begin
         // reset drain: release one waiting sender a cycle
         tx_cmd.pop     = 1'b1;
         strobe_in      = 1'b1;
         woken_valid_in = 1'b1;
         woken_task_in  = tx_stat.head;
         last_in        = tx_stat.single;
      end else if (accept) begin
         unique case (req_action)
            mqwl_pkg::ACT_SEND_BLOCK, mqwl_pkg::ACT_SEND_NONBLOCK: begin
               strobe_in = 1'b1;
               if (has_room) begin
                  ram_we         = 1'b1;
                  wi_in          = advance(wi_ff, eff_cap);
                  held_in        = held_ff + mqwl_pkg::FILL_W'(1);
                  rx_cmd.pop     = 1'b1;
                  woken_valid_in = !rx_stat.empty;
                  woken_task_in  = rx_stat.empty ? '0 : rx_stat.head;
                  notify_in      = notify_en_ff;
               end else if (req_action == mqwl_pkg::ACT_SEND_BLOCK) begin
                  tx_cmd.append = 1'b1;
                  status_in     = mqwl_pkg::STATUS_BLOCKED;
               end else begin
                  status_in = mqwl_pkg::STATUS_FULL;
               end
            end
            mqwl_pkg::ACT_RECV_BLOCK, mqwl_pkg::ACT_RECV_NONBLOCK: begin
               strobe_in = 1'b1;
               if (has_word) begin
                  ram_re         = 1'b1;
                  rd_sel_in      = 1'b1;
                  ri_in          = advance(ri_ff, eff_cap);
                  held_in        = held_ff - mqwl_pkg::FILL_W'(1);
                  tx_cmd.pop     = 1'b1;
                  woken_valid_in = !tx_stat.empty;
                  woken_task_in  = tx_stat.empty ? '0 : tx_stat.head;
               end else if (req_action == mqwl_pkg::ACT_RECV_BLOCK) begin
                  rx_cmd.append = 1'b1;
                  status_in     = mqwl_pkg::STATUS_BLOCKED;
               end else begin
                  status_in = mqwl_pkg::STATUS_EMPTY;
               end
            end
            mqwl_pkg::ACT_PEEK: begin
               strobe_in = 1'b1;
               if (has_word) begin
                  ram_re    = 1'b1;
                  rd_sel_in = 1'b1;
               end else begin
                  status_in = mqwl_pkg::STATUS_EMPTY;
               end
            end
            mqwl_pkg::ACT_RESET: begin
               strobe_in = 1'b1;
               held_in   = '0;
               ri_in     = '0;
               wi_in     = '0;
               if (!tx_stat.empty) begin
                  tx_cmd.pop     = 1'b1;
                  woken_valid_in = 1'b1;
                  woken_task_in  = tx_stat.head;
                  last_in        = tx_stat.single;
               end
            end
            default: strobe_in = 1'b0;
         endcase
      end
   end

   // word store
   mqwl_ram #(
      .WIDTH (mqwl_pkg::DATA_WIDTH),
      .DEPTH (mqwl_pkg::DEPTH)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wi_ff),
      .wr_data (req_send_data[mqwl_pkg::DATA_WIDTH-1:0]),
      .rd_en   (ram_re),
      .rd_addr (ri_ff),
      .rd_data (ram_rd_data)
   );

   // receiver wait list
   mqwl_wait_list u_rx_list (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .stat  (rx_stat)
   );

   // sender wait list
   mqwl_wait_list u_tx_list (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .stat  (tx_stat)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mqwl_pkg::ST_IDLE;
         held_ff   <= '0;
         ri_ff     <= '0;
         wi_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         ri_ff     <= ri_in;
         wi_ff     <= wi_in;
         strobe_ff <= strobe_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= mqwl_pkg::FILL_W'(mqwl_pkg::DEPTH);
         notify_en_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mqwl_pkg::CSR_CAPACITY:      cap_ff       <= csr_write_data;
            mqwl_pkg::CSR_NOTIFY_ENABLE: notify_en_ff <= csr_write_data[0];
            default:                     cap_ff       <= cap_ff;
         endcase
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (strobe_in) begin
         status_ff      <= status_in;
         rd_sel_ff      <= rd_sel_in;
         woken_valid_ff <= woken_valid_in;
         woken_task_ff  <= woken_task_in;
         notify_ff      <= notify_in;
         fill_ff        <= held_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_data   = rd_sel_ff ? 32'(ram_rd_data) : '0;
   assign rsp_woken_valid = woken_valid_ff;
   assign rsp_woken_task  = woken_task_ff;
   assign rsp_notify      = notify_ff;
   assign rsp_fill_level  = fill_ff;
   assign rsp_last        = last_ff;

   // checks
   `MQWL_ASSERT_IMPLY(a_held_bound, clock, reset, 1'b1,
      held_ff <= mqwl_pkg::FILL_W'(mqwl_pkg::DEPTH), "held count above store depth")
   `MQWL_ASSERT_IMPLY(a_drain_has_sender, clock, reset, state_ff == mqwl_pkg::ST_DRAIN,
      !tx_stat.empty, "drain with empty sender list")
   `MQWL_ASSERT_IMPLY(a_wake_only_done, clock, reset, rsp_strobe && rsp_woken_valid,
      rsp_status == mqwl_pkg::STATUS_DONE, "woken task on a failed transaction")
   `MQWL_ASSERT_NEXT(a_drain_gives_result, clock, reset, busy,
      rsp_strobe, "drain cycle gave no result")

endmodule

[sim/tb_message_queue_with_wait_lists_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_queue_with_wait_lists_unit
// Self-checking bench for the task message queue. A directed list of requests
// covers the empty, full, blocking, wake-up, peek, undefined-code and queue
// reset cases, then random phases run under changing capacity and notify
// settings. Every result is checked field by field against an in-bench model
// of the queue and its two wait lists, or against a directed row's own result.
// ----------------------------------------------------------------------------
module tb_message_queue_with_wait_lists_unit;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 55;
   localparam int SETTLE      = 8;

   // request codes the block must ignore
   localparam logic [mqwl_pkg::ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
   localparam logic [mqwl_pkg::ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

   typedef struct packed {
      logic [mqwl_pkg::STATUS_W-1:0] status;
      logic [31:0]                   rdata;
      logic                          wv;
      logic [mqwl_pkg::TASK_W-1:0]   wt;
      logic                          notify;
      logic [mqwl_pkg::FILL_W-1:0]   fill;
      logic                          last;
   } mq_result_type;

   typedef struct packed {
      logic [mqwl_pkg::ACTION_W-1:0] act;
      logic [mqwl_pkg::TASK_W-1:0]   tid;
      logic [31:0]                   data;
      logic                          typed;
      mq_result_type                 want;
   } directed_row_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [mqwl_pkg::ACTION_W-1:0]    req_action;
   logic [mqwl_pkg::TASK_W-1:0]      req_task_id;
   logic [31:0]                      req_send_data;
   logic                             rsp_strobe;
   logic [mqwl_pkg::STATUS_W-1:0]    rsp_status;
   logic [31:0]                      rsp_read_data;
   logic                             rsp_woken_valid;
   logic [mqwl_pkg::TASK_W-1:0]      rsp_woken_task;
   logic                             rsp_notify;
   logic [mqwl_pkg::FILL_W-1:0]      rsp_fill_level;
   logic                             rsp_last;
   logic                             csr_write_enable;
   logic [mqwl_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mqwl_pkg::CSR_DATA_W-1:0]  csr_write_data;

   // queue model state
   logic [31:0]                      word_store [mqwl_pkg::DEPTH];
   logic                             slot_written [mqwl_pkg::DEPTH];
   int                               rd_idx;
   int                               wr_idx;
   int                               held;
   logic [mqwl_pkg::TASK_W-1:0]      rx_waiters [$];
   logic [mqwl_pkg::TASK_W-1:0]      tx_waiters [$];
   logic [mqwl_pkg::CSR_DATA_W-1:0]  cap_reg;
   logic                             notify_reg;

   mq_result_type                    pending_results [$];
   directed_row_type                 directed_rows [$];

   int                               gap_pct;
   int                               cycle_count;
   int                               mismatches;
   int                               n_requests;
   int                               n_results;
   int                               n_wakes;
   int                               n_blocked;
   int                               n_refused;
   int                               n_notify;

   message_queue_with_wait_lists_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_task_id      (req_task_id),
      .req_send_data    (req_send_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_task   (rsp_woken_task),
      .rsp_notify       (rsp_notify),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always #CLK_HALF clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // capacity as the queue applies it
   function automatic int eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > mqwl_pkg::DEPTH) return mqwl_pkg::DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic int next_slot(input int idx);
      return (idx + 1 >= eff_cap()) ? 0 : idx + 1;
   endfunction

   // move a task to the tail of a wait list, dropped when the list is full
   function automatic void enlist(input logic to_senders,
                                  input logic [mqwl_pkg::TASK_W-1:0] tid);
      if (to_senders) begin
         for (int i = 0; i < tx_waiters.size(); i++)
            if (tx_waiters[i] == tid) begin
               tx_waiters.delete(i);
               break;
            end
         if (tx_waiters.size() < mqwl_pkg::MAX_TASKS) tx_waiters.push_back(tid);
      end else begin
         for (int i = 0; i < rx_waiters.size(); i++)
            if (rx_waiters[i] == tid) begin
               rx_waiters.delete(i);
               break;
            end
         if (rx_waiters.size() < mqwl_pkg::MAX_TASKS) rx_waiters.push_back(tid);
      end
   endfunction

   // update the queue model for one request and queue up its results
   function automatic void apply_request(input logic [mqwl_pkg::ACTION_W-1:0] act,
                                         input logic [mqwl_pkg::TASK_W-1:0] tid,
                                         input logic [31:0] data);
      mq_result_type r;
      r = '0;
      r.last = 1'b1;
      case (act)
         mqwl_pkg::ACT_SEND_BLOCK, mqwl_pkg::ACT_SEND_NONBLOCK: begin
            if (held < eff_cap()) begin
               word_store[wr_idx] = data;
               slot_written[wr_idx] = 1'b1;
               wr_idx = next_slot(wr_idx);
               held++;
               r.status = mqwl_pkg::STATUS_DONE;
               r.notify = notify_reg;
               if (rx_waiters.size() != 0) begin
                  r.wv = 1'b1;
                  r.wt = rx_waiters.pop_front();
               end
            end else if (act == mqwl_pkg::ACT_SEND_BLOCK) begin
               enlist(1'b1, tid);
               r.status = mqwl_pkg::STATUS_BLOCKED;
            end else begin
               r.status = mqwl_pkg::STATUS_FULL;
            end
            r.fill = mqwl_pkg::FILL_W'(held);
            pending_results.push_back(r);
         end
         mqwl_pkg::ACT_RECV_BLOCK, mqwl_pkg::ACT_RECV_NONBLOCK: begin
            if (held > 0) begin
               r.rdata = word_store[rd_idx];
               rd_idx = next_slot(rd_idx);
               held--;
               r.status = mqwl_pkg::STATUS_DONE;
               if (tx_waiters.size() != 0) begin
                  r.wv = 1'b1;
                  r.wt = tx_waiters.pop_front();
               end
            end else if (act == mqwl_pkg::ACT_RECV_BLOCK) begin
               enlist(1'b0, tid);
               r.status = mqwl_pkg::STATUS_BLOCKED;
            end else begin
               r.status = mqwl_pkg::STATUS_EMPTY;
            end
            r.fill = mqwl_pkg::FILL_W'(held);
            pending_results.push_back(r);
         end
         mqwl_pkg::ACT_PEEK: begin
            if (held > 0) begin
               r.status = mqwl_pkg::STATUS_DONE;
               r.rdata = word_store[rd_idx];
            end else begin
               r.status = mqwl_pkg::STATUS_EMPTY;
            end
            r.fill = mqwl_pkg::FILL_W'(held);
            pending_results.push_back(r);
         end
         mqwl_pkg::ACT_RESET: begin
            rd_idx = 0;
            wr_idx = 0;
            held = 0;
            r.status = mqwl_pkg::STATUS_DONE;
            if (tx_waiters.size() == 0) begin
               pending_results.push_back(r);
            end else begin
               // one result per released sender, last on the final one
               while (tx_waiters.size() != 0) begin
                  r.wv = 1'b1;
                  r.wt = tx_waiters.pop_front();
                  r.last = (tx_waiters.size() == 0);
                  pending_results.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // plain single-result outcome with no data, wake or notify
   function automatic mq_result_type plain_outcome(
      input logic [mqwl_pkg::STATUS_W-1:0] st,
      input logic [mqwl_pkg::FILL_W-1:0]   fill
   );
      mq_result_type r;
      r = '0;
      r.status = st;
      r.fill = fill;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input logic [mqwl_pkg::ACTION_W-1:0] act,
                                   input logic [mqwl_pkg::TASK_W-1:0] tid,
                                   input logic [31:0] data,
                                   input logic typed,
                                   input mq_result_type want);
      directed_row_type row;
      row.act = act;
      row.tid = tid;
      row.data = data;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // offer one transaction, with random idle cycles first
   task automatic put_item(input logic [mqwl_pkg::ACTION_W-1:0] act,
                           input logic [mqwl_pkg::TASK_W-1:0] tid,
                           input logic [31:0] data, input logic typed,
                           input mq_result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_task_id <= tid;
      req_send_data <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_request(act, tid, data);
      if (typed) pending_results[pending_results.size() - 1] = want;
      n_requests++;
   endtask

   // let every outstanding result arrive, then idle for the settle period
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mqwl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mqwl_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == mqwl_pkg::CSR_CAPACITY) cap_reg = val;
      else notify_reg = val[0];
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      mq_result_type want;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (rsp_woken_valid === 1'b1) n_wakes++;
         if (rsp_notify === 1'b1) n_notify++;
         if (rsp_status === mqwl_pkg::STATUS_BLOCKED) n_blocked++;
         if (rsp_status === mqwl_pkg::STATUS_FULL || rsp_status === mqwl_pkg::STATUS_EMPTY)
            n_refused++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d data 0x%0h",
                     $time, rsp_status, rsp_read_data);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("read_data", want.rdata, rsp_read_data);
            check_field("woken_valid", want.wv, rsp_woken_valid);
            check_field("woken_task", want.wt, rsp_woken_task);
            check_field("notify", want.notify, rsp_notify);
            check_field("fill_level", want.fill, rsp_fill_level);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // stimulus
   initial begin
      directed_row_type                row;
      mq_result_type                   none;
      logic [mqwl_pkg::ACTION_W-1:0]   act;
      logic [31:0]                     data;
      logic [mqwl_pkg::CSR_DATA_W-1:0] cap_val;
      int                              roll;
      int                              n_done;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_action = mqwl_pkg::ACT_PEEK;
      req_task_id = '0;
      req_send_data = '0;
      csr_write_enable = 1'b0;
      csr_index = mqwl_pkg::CSR_CAPACITY;
      csr_write_data = '0;
      none = '0;
      gap_pct = 33;
      cycle_count = 0;
      mismatches = 0;
      n_requests = 0;
      n_results = 0;
      n_wakes = 0;
      n_blocked = 0;
      n_refused = 0;
      n_notify = 0;
      rd_idx = 0;
      wr_idx = 0;
      held = 0;
      cap_reg = 5'd16;
      notify_reg = 1'b0;
      for (int i = 0; i < mqwl_pkg::DEPTH; i++) begin
         word_store[i] = '0;
         slot_written[i] = 1'b0;
      end

      // directed list, first half at reset settings
      add_row(mqwl_pkg::ACT_PEEK, 3'd0, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_EMPTY, 5'd0));
      add_row(mqwl_pkg::ACT_RECV_NONBLOCK, 3'd7, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_EMPTY, 5'd0));
      add_row(mqwl_pkg::ACT_RECV_BLOCK, 3'd3, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_BLOCKED, 5'd0));
      add_row(mqwl_pkg::ACT_RECV_BLOCK, 3'd5, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_BLOCKED, 5'd0));
      // same receiver again moves to the tail
      add_row(mqwl_pkg::ACT_RECV_BLOCK, 3'd3, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_BLOCKED, 5'd0));
      add_row(mqwl_pkg::ACT_SEND_BLOCK, 3'd7, 32'hFFFF_FFFF, 1'b0, none);
      add_row(mqwl_pkg::ACT_PEEK, 3'd1, 32'h0, 1'b0, none);
      add_row(mqwl_pkg::ACT_SEND_NONBLOCK, 3'd0, 32'h0, 1'b0, none);
      add_row(ACT_UNDEF_LO, 3'd2, 32'h1234_5678, 1'b0, none);
      add_row(ACT_UNDEF_HI, 3'd5, 32'h8765_4321, 1'b0, none);
      add_row(mqwl_pkg::ACT_RECV_BLOCK, 3'd2, 32'h0, 1'b0, none);
      add_row(mqwl_pkg::ACT_RESET, 3'd4, 32'h0, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_DONE, 5'd0));
      // second half at capacity 1 with notify on
      add_row(mqwl_pkg::ACT_SEND_NONBLOCK, 3'd1, 32'hA5A5_A5A5, 1'b0, none);
      add_row(mqwl_pkg::ACT_SEND_NONBLOCK, 3'd1, 32'h5A5A_5A5A, 1'b1,
              plain_outcome(mqwl_pkg::STATUS_FULL, 5'd1));
      for (int t = mqwl_pkg::MAX_TASKS - 1; t >= 0; t--)
         add_row(mqwl_pkg::ACT_SEND_BLOCK, mqwl_pkg::TASK_W'(t), 32'h0, 1'b1,
                 plain_outcome(mqwl_pkg::STATUS_BLOCKED, 5'd1));
      add_row(mqwl_pkg::ACT_RECV_BLOCK, 3'd6, 32'h0, 1'b0, none);
      add_row(mqwl_pkg::ACT_RESET, 3'd0, 32'h0, 1'b0, none);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (i == 12) begin
            wait_idle();
            csr_write(mqwl_pkg::CSR_CAPACITY, 5'd1);
            csr_write(mqwl_pkg::CSR_NOTIFY_ENABLE, 5'd1);
         end
         put_item(row.act, row.tid, row.data, row.typed, row.want);
      end

      // random phases, each under its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         case (ph)
            0: cap_val = 5'd16;
            1: cap_val = 5'd2;
            2: cap_val = 5'd0;
            3: cap_val = 5'd31;
            4: cap_val = 5'd1;
            5: cap_val = 5'd4;
            default: cap_val = mqwl_pkg::CSR_DATA_W'($urandom_range(0, 31));
         endcase
         csr_write(mqwl_pkg::CSR_CAPACITY, cap_val);
         if (ph != 5)
            csr_write(mqwl_pkg::CSR_NOTIFY_ENABLE, mqwl_pkg::CSR_DATA_W'(ph % 2));
         gap_pct = (ph == 3 || ph == 4) ? 0 : 33;
         n_done = 0;
         while (n_done < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 22) act = mqwl_pkg::ACT_SEND_BLOCK;
            else if (roll < 36) act = mqwl_pkg::ACT_SEND_NONBLOCK;
            else if (roll < 58) act = mqwl_pkg::ACT_RECV_BLOCK;
            else if (roll < 70) act = mqwl_pkg::ACT_RECV_NONBLOCK;
            else if (roll < 80) act = mqwl_pkg::ACT_PEEK;
            else if (roll < 86) act = mqwl_pkg::ACT_RESET;
            else if (roll < 88) act = ACT_UNDEF_LO;
            else if (roll < 90) act = ACT_UNDEF_HI;
            else act = mqwl_pkg::ACT_SEND_BLOCK;
            // never read a slot that has not been written yet
            if ((act == mqwl_pkg::ACT_RECV_BLOCK || act == mqwl_pkg::ACT_RECV_NONBLOCK ||
                 act == mqwl_pkg::ACT_PEEK) && held > 0 && !slot_written[rd_idx])
               act = mqwl_pkg::ACT_SEND_NONBLOCK;
            roll = $urandom_range(0, 9);
            if (roll == 0) data = 32'hFFFF_FFFF;
            else if (roll == 1) data = 32'h0;
            else data = $urandom;
            put_item(act, mqwl_pkg::TASK_W'($urandom_range(0, mqwl_pkg::MAX_TASKS - 1)),
                     data, 1'b0, none);
            if (act != ACT_UNDEF_LO && act != ACT_UNDEF_HI) n_done++;
         end
      end

      // drain and finish
      wait_idle();
      $display("run covered %0d requests and checked %0d results", n_requests, n_results);
      $display("  %0d wake-ups, %0d blocked, %0d full or empty, %0d notify pulses",
               n_wakes, n_blocked, n_refused, n_notify);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/mqwl_pkg.sv
hdl/mqwl_ram.sv
hdl/mqwl_wait_list.sv
hdl/message_queue_with_wait_lists_unit.sv
sim/tb_message_queue_with_wait_lists_unit.sv
